// ===== rtl/core/utf8d_pkg.sv =====
// Shared types, status codes and helpers for the UTF-8 code point decoder.
// No dependencies; imported by utf8d_decode and utf8_code_point_decoder.
`default_nettype none

package utf8d_pkg;

   localparam logic [1:0] ST_VALID   = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_TRUNC   = 2'd2;
   localparam logic [1:0] ST_END     = 2'd3;

   localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

   localparam int MaxResults = 2;

   typedef struct packed {
      logic [2:0]  exp_len;
      logic [2:0]  seen;
      logic [20:0] partial;
      logic        ended;
   } utf8d_state_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  status;
      logic [31:0] start_offset;
      logic [2:0]  byte_count;
      logic        last;
   } utf8d_result_type;

   function automatic utf8d_result_type make_res(input logic [20:0] cp,
                                                 input logic [1:0]  st,
                                                 input logic [31:0] ofs,
                                                 input logic [2:0]  cnt,
                                                 input logic        lst);
      utf8d_result_type r;
      r.code_point   = cp;
      r.status       = st;
      r.start_offset = ofs;
      r.byte_count   = cnt;
      r.last         = lst;
      return r;
   endfunction

   // Shortest-form and upper-limit check for a finished sequence.
   function automatic logic in_range(input logic [2:0] len, input logic [20:0] v);
      logic ok;
      ok = 1'b0;
      case (len)
         3'd2: ok = (v >= 21'h000080) && (v <= 21'h0007FF);
         3'd3: ok = (v >= 21'h000800) && (v <= 21'h00FFFF);
         3'd4: ok = (v >= 21'h010000) && (v <= 21'h10FFFF);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8d_decode.sv =====
// Single-pass byte decoder: next state, next offset and up to two results.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_decode import utf8d_pkg::*; #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic [7:0]              data_byte,
   input  logic                    stream_end,
   input  utf8d_state_type         st,
   input  logic [OFFSET_WIDTH-1:0] ofs,
   output utf8d_state_type         st_nxt,
   output logic [OFFSET_WIDTH-1:0] ofs_nxt,
   output logic [1:0]              res_num,
   output utf8d_result_type        res0,
   output utf8d_result_type        res1
);

   function automatic logic [31:0] to32(input logic [OFFSET_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[31:0];
   endfunction

   logic                    is_open;
   logic                    is_cont;
   logic [20:0]             acc;
   logic [2:0]              seen_inc;
   logic [OFFSET_WIDTH-1:0] ofs_close;
   logic [OFFSET_WIDTH-1:0] ofs_full;
   logic [OFFSET_WIDTH-1:0] base;
   logic                    lead_emits;
   utf8d_result_type        lead_res;

   assign is_open   = (st.exp_len != 3'd0);
   assign is_cont   = (data_byte[7:6] == 2'b10);
   assign acc       = {st.partial[14:0], data_byte[5:0]};
   assign seen_inc  = st.seen + 3'd1;
   assign ofs_close = ofs + OFFSET_WIDTH'(st.seen);
   assign ofs_full  = ofs + OFFSET_WIDTH'(seen_inc);
   assign base      = is_open ? ofs_close : ofs;

   // Lead byte that completes at once: ASCII or an illegal lead.
   always_comb begin
      lead_emits = 1'b0;
      lead_res   = '0;
      if (!data_byte[7]) begin
         lead_emits = 1'b1;
         lead_res   = make_res({13'd0, data_byte}, ST_VALID, to32(base), 3'd1, 1'b1);
      end else if (data_byte[7:6] == 2'b10 || data_byte[7:3] == 5'b11111) begin
         lead_emits = 1'b1;
         lead_res   = make_res(REPLACEMENT, ST_INVALID, to32(base), 3'd1, 1'b1);
      end
   end

   always_comb begin
      st_nxt  = st;
      ofs_nxt = ofs;
      res_num = 2'd0;
      res0    = '0;
      res1    = '0;
      if (st.ended) begin
         res_num = 2'd0;
      end else if (stream_end) begin
         if (is_open) begin
            res0    = make_res(REPLACEMENT, ST_TRUNC, to32(ofs), st.seen, 1'b0);
            res1    = make_res(REPLACEMENT, ST_END, to32(ofs_close), 3'd0, 1'b1);
            res_num = 2'd2;
         end else begin
            res0    = make_res(REPLACEMENT, ST_END, to32(ofs), 3'd0, 1'b1);
            res_num = 2'd1;
         end
         st_nxt       = '0;
         st_nxt.ended = 1'b1;
         ofs_nxt      = ofs_close;
      end else if (is_open && is_cont) begin
         st_nxt.partial = acc;
         st_nxt.seen    = seen_inc;
         if (seen_inc >= st.exp_len) begin
            if (in_range(st.exp_len, acc)) begin
               res0 = make_res(acc, ST_VALID, to32(ofs), seen_inc, 1'b1);
            end else begin
               res0 = make_res(REPLACEMENT, ST_INVALID, to32(ofs), seen_inc, 1'b1);
            end
            res_num = 2'd1;
            st_nxt  = '0;
            ofs_nxt = ofs_full;
         end
      end else begin
         // Close a broken sequence, then treat this byte as a lead byte.
         if (is_open) begin
            res0    = make_res(REPLACEMENT, ST_INVALID, to32(ofs), st.seen, 1'b0);
            res_num = 2'd1;
         end
         st_nxt  = '0;
         ofs_nxt = base;
         if (lead_emits) begin
            ofs_nxt = base + OFFSET_WIDTH'(1);
            if (is_open) begin
               res1    = lead_res;
               res_num = 2'd2;
            end else begin
               res0    = lead_res;
               res_num = 2'd1;
            end
         end else begin
            res0.last   = 1'b1;
            st_nxt.seen = 3'd1;
            if (data_byte[7:5] == 3'b110) begin
               st_nxt.exp_len = 3'd2;
               st_nxt.partial = {16'd0, data_byte[4:0]};
            end else if (data_byte[7:4] == 4'b1110) begin
               st_nxt.exp_len = 3'd3;
               st_nxt.partial = {17'd0, data_byte[3:0]};
            end else begin
               st_nxt.exp_len = 3'd4;
               st_nxt.partial = {18'd0, data_byte[2:0]};
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_code_point_decoder.sv =====
// Top level of the UTF-8 code point decoder: request stage, decode, result queue.
// Depends on utf8d_pkg and utf8d_decode.
`default_nettype none

// One stream byte enters per request; an end request (req_stream_end high) closes the
// stream. Each request gives zero, one or two results: a code point with its start
// offset and byte count, or U+FFFD with an error status (invalid, truncated at end,
// end of stream). rsp_last marks the final result of a request. A request is
// registered, decoded combinationally and its results are pushed into a four-entry
// result queue. The block takes one request per cycle as long as the queue has room
// for two results; the result side drains one result per cycle while rsp_ready is
// high. Requests after the end of stream are taken and dropped.
// Offsets count modulo 2^OFFSET_WIDTH and are shown in the low 32 bits.
module utf8_code_point_decoder import utf8d_pkg::*; #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_start_offset,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last
);

   localparam int QDepth = 4;

   // Request stage
   logic       stg_valid_ff, stg_valid_in;
   logic [7:0] stg_byte_ff, stg_byte_in;
   logic       stg_end_ff, stg_end_in;
   logic       stg_go;

   // Decoder state
   utf8d_state_type         st_ff, st_in;
   logic [OFFSET_WIDTH-1:0] ofs_ff, ofs_in;

   // Result queue
   utf8d_result_type q_ff [QDepth];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             pop;

   utf8d_state_type         dec_st;
   logic [OFFSET_WIDTH-1:0] dec_ofs;
   logic [1:0]              dec_num;
   utf8d_result_type        dec_r0, dec_r1;
   utf8d_result_type        head;

   utf8d_decode #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_decode (
      .data_byte  (stg_byte_ff),
      .stream_end (stg_end_ff),
      .st         (st_ff),
      .ofs        (ofs_ff),
      .st_nxt     (dec_st),
      .ofs_nxt    (dec_ofs),
      .res_num    (dec_num),
      .res0       (dec_r0),
      .res1       (dec_r1)
   );

   // Advance the staged request only when the queue can absorb a worst-case request.
   assign stg_go    = stg_valid_ff && (cnt_ff <= 3'(QDepth - MaxResults));
   assign req_ready = !stg_valid_ff || stg_go;

   always_comb begin
      stg_valid_in = stg_valid_ff;
      stg_byte_in  = stg_byte_ff;
      stg_end_in   = stg_end_ff;
      if (req_ready) begin
         stg_valid_in = req_valid;
         stg_byte_in  = req_data_byte;
         stg_end_in   = req_stream_end;
      end
   end

   assign st_in  = stg_go ? dec_st  : st_ff;
   assign ofs_in = stg_go ? dec_ofs : ofs_ff;

   // Result side: head of the queue drives the ports.
   assign head             = q_ff[rd_ptr_ff];
   assign rsp_valid        = (cnt_ff != 3'd0);
   assign rsp_code_point   = head.code_point;
   assign rsp_status       = head.status;
   assign rsp_start_offset = head.start_offset;
   assign rsp_byte_count   = head.byte_count;
   assign rsp_last         = head.last;
   assign pop              = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (stg_go) begin
         wr_ptr_in = wr_ptr_ff + dec_num;
         cnt_in    = cnt_in + {1'b0, dec_num};
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
         cnt_in    = cnt_in - 3'd1;
      end
   end

   // Hold payload; no reset needed on queue contents or staged byte.
   always_ff @(posedge clock) begin
      stg_byte_ff <= stg_byte_in;
      stg_end_ff  <= stg_end_in;
      if (stg_go && dec_num != 2'd0) begin
         q_ff[wr_ptr_ff] <= dec_r0;
      end
      if (stg_go && dec_num == 2'd2) begin
         q_ff[wr_ptr_ff + 2'd1] <= dec_r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         st_ff        <= '0;
         ofs_ff       <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         st_ff        <= st_in;
         ofs_ff       <= ofs_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         cnt_ff       <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QDepth))
      else $error("result queue overflow");

   a_open_seen: assert property (@(posedge clock) disable iff (reset)
      (st_ff.exp_len == 3'd0) == (st_ff.seen == 3'd0))
      else $error("open sequence and byte count disagree");

   a_ended_sticky: assert property (@(posedge clock) disable iff (reset)
      st_ff.ended |=> st_ff.ended)
      else $error("end of stream flag cleared");

   a_end_reports: assert property (@(posedge clock) disable iff (reset)
      (stg_go && stg_end_ff && !st_ff.ended) |-> (dec_num != 2'd0))
      else $error("end of stream produced no result");

   a_err_repl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_VALID) |-> (rsp_code_point == REPLACEMENT))
      else $error("error result without replacement character");
`endif

endmodule

`default_nettype wire

// ===== test/utf8_code_point_decoder_tb.sv =====
// Self-checking testbench for utf8_code_point_decoder: directed, back-pressure, random
// and end-of-stream tests against a local decode predictor. Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8_code_point_decoder_tb import utf8d_pkg::*; ();

   // Longest quiet stretch of a correct run is the receiver hold-off (HOLD_CYCLES);
   // allow several times that before calling the run hung.
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned TARGET_ITEMS   = 950;
   localparam int unsigned SETTLE_CYCLES  = 10;
   localparam int unsigned MAX_REPORTS    = 10;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte  = 8'h00;
   logic        req_stream_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [20:0] rsp_code_point;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_start_offset;
   logic [2:0]  rsp_byte_count;
   logic        rsp_last;

   utf8_code_point_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_stream_end   (req_stream_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_status       (rsp_status),
      .rsp_start_offset (rsp_start_offset),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // Decoded results still owed by the block, oldest first.
   utf8d_result_type expected_results [$];

   int unsigned error_count = 0;
   int unsigned req_count   = 0;
   bit          req_gaps_on = 1'b1;
   int unsigned hold_request = 0;   // set by a test; receiver turns it into a stall

   // Local copy of the decoder state.
   logic [2:0]  seq_len       = 3'd0;
   logic [2:0]  seq_seen      = 3'd0;
   logic [20:0] seq_value     = 21'd0;
   logic [31:0] next_offset   = 32'd0;
   logic        stream_closed = 1'b0;

   //------------------------------------------------------------------
   // Decode predictor
   //------------------------------------------------------------------
   function automatic utf8d_result_type result_of(input logic [20:0] cp,
                                                  input logic [1:0]  st,
                                                  input logic [31:0] ofs,
                                                  input logic [2:0]  cnt);
      utf8d_result_type r;
      r.code_point   = cp;
      r.status       = st;
      r.start_offset = ofs;
      r.byte_count   = cnt;
      r.last         = 1'b0;
      return r;
   endfunction

   // Shortest form and upper limit per sequence length; surrogates pass.
   function automatic bit value_fits(input logic [2:0] len, input logic [20:0] v);
      case (len)
         3'd2:    return (v >= 21'h80)    && (v <= 21'h7FF);
         3'd3:    return (v >= 21'h800)   && (v <= 21'hFFFF);
         3'd4:    return (v >= 21'h10000) && (v <= 21'h10FFFF);
         default: return 1'b0;
      endcase
   endfunction

   // Close the open sequence and advance the offset past its bytes.
   task automatic close_sequence();
      next_offset = next_offset + 32'(seq_seen);
      seq_len     = 3'd0;
      seq_seen    = 3'd0;
      seq_value   = 21'd0;
   endtask

   task automatic predict_request(input logic [7:0] b, input logic fin);
      utf8d_result_type step_res [2];
      int               n;
      bit               consumed;
      n        = 0;
      consumed = 1'b0;
      if (stream_closed) return;   // drop everything after end of stream

      if (fin) begin
         // Open sequence at end: report it truncated, then the end itself.
         if (seq_len != 3'd0) begin
            step_res[n] = result_of(REPLACEMENT, ST_TRUNC, next_offset, seq_seen);
            n++;
            close_sequence();
         end
         step_res[n] = result_of(REPLACEMENT, ST_END, next_offset, 3'd0);
         n++;
         stream_closed = 1'b1;
      end else begin
         if (seq_len != 3'd0) begin
            if (b[7:6] == 2'b10) begin
               seq_value = {seq_value[14:0], b[5:0]};
               seq_seen  = seq_seen + 3'd1;
               consumed  = 1'b1;
               if (seq_seen >= seq_len) begin
                  if (value_fits(seq_len, seq_value))
                     step_res[n] = result_of(seq_value, ST_VALID, next_offset, seq_seen);
                  else
                     step_res[n] = result_of(REPLACEMENT, ST_INVALID, next_offset, seq_seen);
                  n++;
                  close_sequence();
               end
            end else begin
               // Bad continuation: report what was taken, then treat byte as a lead.
               step_res[n] = result_of(REPLACEMENT, ST_INVALID, next_offset, seq_seen);
               n++;
               close_sequence();
            end
         end
         if (!consumed) begin
            if (b[7] == 1'b0) begin
               step_res[n] = result_of({13'd0, b}, ST_VALID, next_offset, 3'd1);
               n++;
               seq_seen = 3'd1;
               close_sequence();
            end else if (b[7:5] == 3'b110) begin
               seq_len   = 3'd2;
               seq_value = {16'd0, b[4:0]};
               seq_seen  = 3'd1;
            end else if (b[7:4] == 4'b1110) begin
               seq_len   = 3'd3;
               seq_value = {17'd0, b[3:0]};
               seq_seen  = 3'd1;
            end else if (b[7:3] == 5'b11110) begin
               seq_len   = 3'd4;
               seq_value = {18'd0, b[2:0]};
               seq_seen  = 3'd1;
            end else begin
               step_res[n] = result_of(REPLACEMENT, ST_INVALID, next_offset, 3'd1);
               n++;
               seq_seen = 3'd1;
               close_sequence();
            end
         end
      end

      if (n > 0) step_res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(step_res[i]);
   endtask

   //------------------------------------------------------------------
   // Request side
   //------------------------------------------------------------------
   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Offer one request, hold it until accepted, then predict its results.
   task automatic send_req(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_stream_end <= fin;
      do @(posedge clock); while (!req_ready);
      predict_request(b, fin);
      req_count++;
   endtask

   // Encode v as a len-byte sequence and send the first nbytes of it. Values
   // outside the length's range give overlong or out-of-range sequences.
   task automatic send_sequence(input int unsigned len, input logic [20:0] v,
                                input int unsigned nbytes);
      logic [7:0] bytes [4];
      case (len)
         2: begin
            bytes[0] = {3'b110, v[10:6]};
            bytes[1] = {2'b10, v[5:0]};
         end
         3: begin
            bytes[0] = {4'b1110, v[15:12]};
            bytes[1] = {2'b10, v[11:6]};
            bytes[2] = {2'b10, v[5:0]};
         end
         default: begin
            bytes[0] = {5'b11110, v[20:18]};
            bytes[1] = {2'b10, v[17:12]};
            bytes[2] = {2'b10, v[11:6]};
            bytes[3] = {2'b10, v[5:0]};
         end
      endcase
      for (int i = 0; i < nbytes; i++) send_req(bytes[i], 1'b0);
   endtask

   // One random unit of stream: mostly well-formed code points, some raw
   // sequences (overlong / out of range), cut-off sequences and noise bytes.
   task automatic send_random_unit();
      int unsigned pick;
      int unsigned len;
      logic [20:0] v;
      pick = $urandom_range(99);
      len  = $urandom_range(4, 2);
      case (len)
         2:       v = 21'($urandom_range(32'h7FF, 32'h80));
         3:       v = 21'($urandom_range(32'hFFFF, 32'h800));
         default: v = 21'($urandom_range(32'h10FFFF, 32'h10000));
      endcase
      if (pick < 25) begin
         send_req(8'($urandom_range(127)), 1'b0);
      end else if (pick < 65) begin
         send_sequence(len, v, len);
      end else if (pick < 78) begin
         send_sequence(len, 21'($urandom), len);
      end else if (pick < 90) begin
         // Leave the sequence short; the next unit breaks it.
         send_sequence(len, v, $urandom_range(len - 1, 1));
      end else begin
         send_req(8'($urandom_range(255)), 1'b0);
      end
   endtask

   //------------------------------------------------------------------
   // Result side: random stalls, plus long hold-offs on request
   //------------------------------------------------------------------
   initial begin : receiver
      int unsigned stall_left;
      int unsigned r;
      bit          stalls_on;
      stall_left = 0;
      stalls_on  = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if ($urandom_range(255) == 0) stalls_on = ~stalls_on;
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (stalls_on) begin
               r = $urandom_range(99);
               if (r < 20)      stall_left = $urandom_range(3, 1);
               else if (r < 23) stall_left = $urandom_range(50, 10);
            end
         end
      end
   end

   // Compare every accepted result with the oldest expectation.
   initial begin : result_checker
      utf8d_result_type want;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected result: cp=%h st=%0d ofs=%0d cnt=%0d last=%0b",
                           rsp_code_point, rsp_status, rsp_start_offset,
                           rsp_byte_count, rsp_last);
            end else begin
               want = expected_results.pop_front();
               if (rsp_code_point !== want.code_point || rsp_status !== want.status ||
                   rsp_start_offset !== want.start_offset ||
                   rsp_byte_count !== want.byte_count || rsp_last !== want.last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display({"mismatch: exp cp=%h st=%0d ofs=%0d cnt=%0d last=%0b,",
                               " got cp=%h st=%0d ofs=%0d cnt=%0d last=%0b"},
                              want.code_point, want.status, want.start_offset,
                              want.byte_count, want.last, rsp_code_point, rsp_status,
                              rsp_start_offset, rsp_byte_count, rsp_last);
               end
            end
         end
      end
   end

   // Stop a hung run: count cycles in which neither channel moves anything.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   //------------------------------------------------------------------
   // Tests
   //------------------------------------------------------------------
   task automatic test_directed();
      // ASCII extremes.
      send_req(8'h00, 1'b0);
      send_req(8'h7F, 1'b0);
      // Largest two-, three- and four-byte values.
      send_req(8'hDF, 1'b0); send_req(8'hBF, 1'b0);
      send_req(8'hEF, 1'b0); send_req(8'hBF, 1'b0); send_req(8'hBF, 1'b0);
      send_req(8'hF4, 1'b0); send_req(8'h8F, 1'b0);
      send_req(8'hBF, 1'b0); send_req(8'hBF, 1'b0);
      // Overlong two-byte form: whole sequence consumed.
      send_req(8'hC0, 1'b0); send_req(8'h80, 1'b0);
      // Surrogate passes unchecked.
      send_req(8'hED, 1'b0); send_req(8'hA0, 1'b0); send_req(8'h80, 1'b0);
      // Invalid lead bytes at both ends of both ranges.
      send_req(8'h80, 1'b0);
      send_req(8'hBF, 1'b0);
      send_req(8'hFF, 1'b0);
      send_req(8'hF8, 1'b0);
      // Bad continuation that is itself ASCII: two results in one request.
      send_req(8'hC3, 1'b0); send_req(8'h41, 1'b0);
      // Bad continuation after two good bytes, the offender opening a new sequence.
      send_req(8'hE2, 1'b0); send_req(8'h82, 1'b0); send_req(8'hE0, 1'b0);
   endtask

   // Hold the receiver off while requests keep coming, so the queue fills and
   // the block has to stall its input.
   task automatic test_backpressure();
      req_gaps_on  = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) send_random_unit();
      req_gaps_on = 1'b1;
   endtask

   task automatic test_random_stream();
      while (req_count < TARGET_ITEMS) begin
         // Alternate stretches with and without request gaps.
         if ($urandom_range(63) == 0) req_gaps_on = ~req_gaps_on;
         send_random_unit();
      end
      req_gaps_on = 1'b1;
   endtask

   // Close the stream with a sequence open, then check later requests are dropped.
   task automatic test_end_of_stream();
      send_req(8'hF0, 1'b0); send_req(8'h9F, 1'b0);
      send_req(8'($urandom_range(255)), 1'b1);
      send_req(8'h41, 1'b0);
      send_req(8'($urandom_range(255)), 1'b1);
      send_req(8'hC3, 1'b0);
   endtask

   initial begin : main
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_random_stream();
      test_end_of_stream();

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // Give stray results time to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
